[hw/rtl/cqgu_pkg.sv]
`default_nettype none
package cqgu_pkg;
	localparam int NumQubits = 10;
	localparam int Dim = 1 << NumQubits;
	localparam int IdxW = NumQubits;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [63:0] word_t;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_APPLY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_TARGET  = 3'd0,
		CFG_CSEL    = 3'd1,
		CFG_CVAL    = 3'd2,
		CFG_C00     = 3'd3,
		CFG_C01     = 3'd4,
		CFG_C10     = 3'd5,
		CFG_C11     = 3'd6,
		CFG_UNUSED  = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_HOLD,
		ST_SCAN,
		ST_RD0,
		ST_RD1,
		ST_MUL,
		ST_SUM,
		ST_WR1
	} state_t;

	// Q2.30 x Q2.30 rounded back to Q2.30, kept 34 bits wide.
	function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [64:0] r;
		begin
			p = a * b;
			r = {p[63], p} + 65'sd536870912;
			return r[63:30];
		end
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v, output logic clip);
		begin
			clip = 1'b0;
			if (v > 36'sd2147483647) begin
				clip = 1'b1;
				return 32'h7FFFFFFF;
			end
			if (v < -36'sd2147483648) begin
				clip = 1'b1;
				return 32'h80000000;
			end
			return v[31:0];
		end
	endfunction
endpackage
`default_nettype wire

[hw/rtl/cqgu_if.sv]
`default_nettype none
interface cqgu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [9:0]  basis_index;
	logic signed [31:0] in_real;
	logic signed [31:0] in_imag;
	modport source(output valid, req_type, basis_index, in_real, in_imag, input ready);
	modport sink(input valid, req_type, basis_index, in_real, in_imag, output ready);
endinterface

interface cqgu_resp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  resp_kind;
	logic signed [31:0] out_real;
	logic signed [31:0] out_imag;
	logic        saturated;
	modport source(output valid, resp_kind, out_real, out_imag, saturated, input ready);
	modport sink(input valid, resp_kind, out_real, out_imag, saturated, output ready);
endinterface
`default_nettype wire

[hw/rtl/cqgu_ram.sv]
`default_nettype none
module cqgu_ram (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire cqgu_pkg::idx_t   waddr,
	input  wire cqgu_pkg::word_t  wdata,
	input  wire cqgu_pkg::idx_t   raddr,
	output cqgu_pkg::word_t       rdata
);
	import cqgu_pkg::*;
	word_t mem [Dim];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/controlled_qubit_gate_update.sv]
`default_nettype none
// Channel  | dir | payload
// req      | in  | req_type, basis_index, in_real, in_imag
// resp     | out | resp_kind, out_real, out_imag, saturated
// cfg      | in  | cfg_we, cfg_index, cfg_data (64 bits)
// Write: result next cycle. Read: ST_RD_HOLD waits out the registered RAM read.
// Apply (target in range): walks all 2^NumQubits indices, one per cycle when
// skipped; a matching pair does two reads, multiply, sum and two writes.
// Reset clears control, loads identity config; amplitude RAM is not cleared.
// A pending result blocks new items until taken; the output register holds it.
module controlled_qubit_gate_update (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	cqgu_req_if.sink         req,
	cqgu_resp_if.source      resp
);
	import cqgu_pkg::*;

	logic [3:0] target_q;
	logic [9:0] csel_q, cval_q;
	word_t c00_q, c01_q, c10_q, c11_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			csel_q <= '0;
			cval_q <= '0;
			c00_q <= 64'h4000000000000000;
			c01_q <= '0;
			c10_q <= '0;
			c11_q <= 64'h4000000000000000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET: target_q <= cfg_data[3:0];
				CFG_CSEL:   csel_q <= cfg_data[9:0];
				CFG_CVAL:   cval_q <= cfg_data[9:0];
				CFG_C00:    c00_q <= cfg_data;
				CFG_C01:    c01_q <= cfg_data;
				CFG_C10:    c10_q <= cfg_data;
				CFG_C11:    c11_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// sweep masks
	idx_t tmask, csel, cval;
	logic tgt_ok;
	always_comb begin
		tgt_ok = ({28'd0, target_q} < NumQubits);
		tmask  = idx_t'(1) << target_q;
		csel   = idx_t'(csel_q) & ~tmask;
		cval   = idx_t'(cval_q) & csel;
	end

	state_t state_q, state_d;
	idx_t sweep_q;
	logic [Dim == 0 ? 0 : IdxW:0] sweep_n;
	logic clip_q;
	word_t a0_q;
	logic signed [33:0] p_q [16];
	word_t n0_q, n1_q;
	logic clipsum;

	logic rvalid_q;
	logic [1:0] rkind_q;
	logic [31:0] rre_q, rim_q;
	logic rsat_q;

	logic we;
	idx_t waddr, raddr;
	word_t wdata, rdata;

	cqgu_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	logic accept;
	assign req.ready = (state_q == ST_IDLE) && !rvalid_q;
	assign accept = req.valid && req.ready;

	assign resp.valid = rvalid_q;
	assign resp.resp_kind = rkind_q;
	assign resp.out_real = rre_q;
	assign resp.out_imag = rim_q;
	assign resp.saturated = rsat_q;

	logic match;
	assign match = ((sweep_q & tmask) == '0) && ((sweep_q & csel) == cval);
	assign sweep_n = {1'b0, sweep_q} + 1'b1;

	// sums of four rounded products
	logic signed [35:0] s0r, s0i, s1r, s1i;
	logic [31:0] q0r, q0i, q1r, q1i;
	logic k0, k1, k2, k3;
	always_comb begin
		s0r = 36'(p_q[0]) - 36'(p_q[1]) + 36'(p_q[2]) - 36'(p_q[3]);
		s0i = 36'(p_q[4]) + 36'(p_q[5]) + 36'(p_q[6]) + 36'(p_q[7]);
		s1r = 36'(p_q[8]) - 36'(p_q[9]) + 36'(p_q[10]) - 36'(p_q[11]);
		s1i = 36'(p_q[12]) + 36'(p_q[13]) + 36'(p_q[14]) + 36'(p_q[15]);
		q0r = sat32(s0r, k0);
		q0i = sat32(s0i, k1);
		q1r = sat32(s1r, k2);
		q1i = sat32(s1i, k3);
		clipsum = k0 | k1 | k2 | k3;
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = sweep_q;
		wdata = n1_q;
		raddr = sweep_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = idx_t'(req.basis_index);
				waddr = idx_t'(req.basis_index);
				wdata = {req.in_real, req.in_imag};
				if (accept) begin
					unique case (req_t'(req.req_type))
						REQ_WRITE: we = 1'b1;
						REQ_READ:  state_d = ST_RD_HOLD;
						REQ_APPLY: state_d = tgt_ok ? ST_SCAN : ST_IDLE;
						default:   ;
					endcase
				end
			end
			ST_RD_HOLD: state_d = ST_IDLE;
			ST_SCAN: begin
				raddr = sweep_q;
				if (match) state_d = ST_RD0;
				else if (sweep_n[IdxW]) state_d = ST_IDLE;
			end
			ST_RD0: begin
				raddr = sweep_q | tmask;
				state_d = ST_RD1;
			end
			ST_RD1: state_d = ST_MUL;
			ST_MUL: state_d = ST_SUM;
			ST_SUM: begin
				we = 1'b1;
				waddr = sweep_q;
				wdata = {q0r, q0i};
				state_d = ST_WR1;
			end
			ST_WR1: begin
				we = 1'b1;
				waddr = sweep_q | tmask;
				wdata = n1_q;
				state_d = sweep_n[IdxW] ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sweep_q <= '0;
			clip_q <= 1'b0;
			rvalid_q <= 1'b0;
			rkind_q <= '0;
			rre_q <= '0;
			rim_q <= '0;
			rsat_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (resp.valid && resp.ready) rvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					sweep_q <= '0;
					clip_q <= 1'b0;
					if (accept) begin
						rkind_q <= req.req_type;
						rre_q <= '0;
						rim_q <= '0;
						rsat_q <= 1'b0;
						if (req_t'(req.req_type) == REQ_WRITE ||
							(req_t'(req.req_type) == REQ_APPLY && !tgt_ok))
							rvalid_q <= 1'b1;
					end
				end
				ST_RD_HOLD: begin
					rre_q <= rdata[63:32];
					rim_q <= rdata[31:0];
					rvalid_q <= 1'b1;
				end
				ST_SCAN: begin
					if (!match) begin
						sweep_q <= sweep_n[IdxW-1:0];
						if (sweep_n[IdxW]) begin
							rsat_q <= clip_q;
							rvalid_q <= 1'b1;
						end
					end
				end
				ST_SUM: clip_q <= clip_q | clipsum;
				ST_WR1: begin
					sweep_q <= sweep_n[IdxW-1:0];
					if (sweep_n[IdxW]) begin
						rsat_q <= clip_q;
						rvalid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: hold a0, form the 16 products, hold second result
	always_ff @(posedge clk) begin
		if (state_q == ST_RD0) a0_q <= rdata;
		if (state_q == ST_RD1) n0_q <= rdata;
		if (state_q == ST_MUL) begin
			p_q[0]  <= qmul(c00_q[63:32], a0_q[63:32]);
			p_q[1]  <= qmul(c00_q[31:0],  a0_q[31:0]);
			p_q[2]  <= qmul(c01_q[63:32], n0_q[63:32]);
			p_q[3]  <= qmul(c01_q[31:0],  n0_q[31:0]);
			p_q[4]  <= qmul(c00_q[63:32], a0_q[31:0]);
			p_q[5]  <= qmul(c00_q[31:0],  a0_q[63:32]);
			p_q[6]  <= qmul(c01_q[63:32], n0_q[31:0]);
			p_q[7]  <= qmul(c01_q[31:0],  n0_q[63:32]);
			p_q[8]  <= qmul(c10_q[63:32], a0_q[63:32]);
			p_q[9]  <= qmul(c10_q[31:0],  a0_q[31:0]);
			p_q[10] <= qmul(c11_q[63:32], n0_q[63:32]);
			p_q[11] <= qmul(c11_q[31:0],  n0_q[31:0]);
			p_q[12] <= qmul(c10_q[63:32], a0_q[31:0]);
			p_q[13] <= qmul(c10_q[31:0],  a0_q[63:32]);
			p_q[14] <= qmul(c11_q[63:32], n0_q[31:0]);
			p_q[15] <= qmul(c11_q[31:0],  n0_q[63:32]);
		end
		if (state_q == ST_SUM) n1_q <= {q1r, q1i};
	end
endmodule
`default_nettype wire

[bench/cqgu_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module cqgu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	cqgu_req_if              req,
	cqgu_resp_if             resp,
	output int               errors,
	output int               pending
);
	import cqgu_pkg::*;

	typedef struct {
		req_t               kind;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               sat;
	} gate_resp_t;

	gate_resp_t  resp_fifo[$];
	word_t       amp_mem[Dim];
	logic [3:0]  tgt;
	logic [9:0]  csel;
	logic [9:0]  cval;
	word_t       m00, m01, m10, m11;
	int          n_err = 0;
	int          n_pend = 0;

	assign errors = n_err;
	assign pending = n_pend;

	// Q2.30 product rounded to nearest, ties up
	function automatic longint rmul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic [31:0] clip32(input longint v, inout logic clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// m0*c0 + m1*c1 on packed real:imag words
	function automatic word_t pair_mac(input word_t m0, input word_t c0, input word_t m1,
		input word_t c1, inout logic clip);
		longint m0r, m0i, m1r, m1i, c0r, c0i, c1r, c1i, sr, si;
		m0r = longint'($signed(m0[63:32]));
		m0i = longint'($signed(m0[31:0]));
		m1r = longint'($signed(m1[63:32]));
		m1i = longint'($signed(m1[31:0]));
		c0r = longint'($signed(c0[63:32]));
		c0i = longint'($signed(c0[31:0]));
		c1r = longint'($signed(c1[63:32]));
		c1i = longint'($signed(c1[31:0]));
		sr = rmul(m0r, c0r) - rmul(m0i, c0i) + rmul(m1r, c1r) - rmul(m1i, c1i);
		si = rmul(m0r, c0i) + rmul(m0i, c0r) + rmul(m1r, c1i) + rmul(m1i, c1r);
		return {clip32(sr, clip), clip32(si, clip)};
	endfunction

	function automatic logic gate_sweep();
		logic      clip;
		idx_t      tmask, sel, want, i1;
		word_t     a0, a1;
		clip = 1'b0;
		if (tgt >= NumQubits)
			return 1'b0;
		tmask = idx_t'(1) << tgt;
		sel = csel & ~tmask;
		want = cval & sel;
		for (int n = 0; n < Dim; n++) begin
			if ((idx_t'(n) & tmask) == 0 && (idx_t'(n) & sel) == want) begin
				i1 = idx_t'(n) | tmask;
				a0 = amp_mem[n];
				a1 = amp_mem[i1];
				amp_mem[n] = pair_mac(m00, a0, m01, a1, clip);
				amp_mem[i1] = pair_mac(m10, a0, m11, a1, clip);
			end
		end
		return clip;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gate_resp_t e;
		if (!arst_n) begin
			tgt = '0;
			csel = '0;
			cval = '0;
			m00 = 64'h4000_0000_0000_0000;
			m01 = '0;
			m10 = '0;
			m11 = 64'h4000_0000_0000_0000;
			resp_fifo.delete();
			n_pend = 0;
		end else begin
			// compare first: a response taken now belongs to an earlier item
			if (resp.valid && resp.ready) begin
				if (resp_fifo.size() == 0) begin
					$error("unexpected response kind %0d", resp.resp_kind);
					n_err++;
				end else begin
					e = resp_fifo.pop_front();
					if (resp.resp_kind !== e.kind) begin
						$error("resp_kind exp %0d got %0d", e.kind, resp.resp_kind);
						n_err++;
					end
					if (resp.out_real !== e.re) begin
						$error("out_real exp %0h got %0h", e.re, resp.out_real);
						n_err++;
					end
					if (resp.out_imag !== e.im) begin
						$error("out_imag exp %0h got %0h", e.im, resp.out_imag);
						n_err++;
					end
					if (resp.saturated !== e.sat) begin
						$error("saturated exp %0b got %0b", e.sat, resp.saturated);
						n_err++;
					end
				end
			end
			if (req.valid && req.ready) begin
				e = '{req_t'(req.req_type), '0, '0, 1'b0};
				case (req_t'(req.req_type))
					REQ_WRITE: begin
						amp_mem[req.basis_index] = {req.in_real, req.in_imag};
						resp_fifo.push_back(e);
					end
					REQ_READ: begin
						{e.re, e.im} = amp_mem[req.basis_index];
						resp_fifo.push_back(e);
					end
					REQ_APPLY: begin
						e.sat = gate_sweep();
						resp_fifo.push_back(e);
					end
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TARGET: tgt = cfg_data[3:0];
					CFG_CSEL:   csel = cfg_data[9:0];
					CFG_CVAL:   cval = cfg_data[9:0];
					CFG_C00:    m00 = cfg_data;
					CFG_C01:    m01 = cfg_data;
					CFG_C10:    m10 = cfg_data;
					CFG_C11:    m11 = cfg_data;
					default: ;
				endcase
			end
			n_pend = resp_fifo.size();
		end
	end
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import cqgu_pkg::*;

	localparam int RandItems = 560;
	localparam int CycleLimit = 20000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	bit          burst;    // no idling on either side while set
	bit          hold_rx;  // ask the receiver for one long hold-off

	cqgu_req_if  req();
	cqgu_resp_if resp();

	controlled_qubit_gate_update i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .resp(resp.source)
	);

	cqgu_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .resp(resp), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run; a hung handshake ends here
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Response side: random stall per item, plus one long hold-off on request
	initial begin
		int n;
		resp.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				resp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				n = burst ? 0 : $urandom_range(0, 6);
				if (n > 0) begin
					resp.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			resp.ready <= 1'b1;
			do @(posedge clk); while (!resp.valid);
		end
	end

	// Offer one item, hold it until taken, then drop valid for a random gap
	task automatic send(req_t kind, idx_t idx, logic [31:0] re, logic [31:0] im);
		int gap;
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.basis_index <= idx;
		req.in_real <= re;
		req.in_imag <= im;
		do @(posedge clk); while (!req.ready);
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain: stop offering, wait for every response, then settle
	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a modest matrix entry, sometimes extreme or fully random
	function automatic logic [63:0] pick_coef();
		logic [31:0] r, i;
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return {$urandom, $urandom};
			2: return 64'h7FFFFFFF_80000000;
			default: begin
				r = 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
				i = 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
				return {r, i};
			end
		endcase
	endfunction

	task automatic random_config();
		logic [3:0] t;
		t = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
		cfg_write(CFG_TARGET, 64'(t));
		cfg_write(CFG_CSEL, 64'($urandom & $urandom & 32'h3FF));
		cfg_write(CFG_CVAL, 64'($urandom & 32'h3FF));
		cfg_write(CFG_C00, pick_coef());
		cfg_write(CFG_C01, pick_coef());
		cfg_write(CFG_C10, pick_coef());
		cfg_write(CFG_C11, pick_coef());
	endtask

	initial begin
		int done;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.basis_index = '0;
		req.in_real = '0;
		req.in_imag = '0;
		burst = 1'b0;
		hold_rx = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the whole store first; reads and sweeps need every entry written.
		// The receiver holds off early on, so the block backs up and stalls us.
		hold_rx = 1'b1;
		for (int i = 0; i < Dim; i++) begin
			burst = (i >= 200 && i < 400);
			send(REQ_WRITE, idx_t'(i), $urandom, $urandom);
		end
		burst = 1'b0;

		// Directed: field extremes, identity sweep at reset config, unknown request
		send(REQ_WRITE, '0, 32'h7FFFFFFF, 32'h80000000);
		send(REQ_WRITE, '1, 32'h80000000, 32'h7FFFFFFF);
		send(REQ_READ, '0, '0, '0);
		send(REQ_READ, '1, '0, '0);
		send(REQ_NONE, 10'h155, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(REQ_APPLY, '0, '0, '0);
		send(REQ_READ, '1, '0, '0);
		drain();

		// Target out of range: nothing moves
		cfg_write(CFG_TARGET, 64'd15);
		send(REQ_APPLY, '0, '0, '0);
		send(REQ_READ, 10'd1, '0, '0);
		drain();

		// Largest target, every control set (target bit included), extreme coefs
		cfg_write(CFG_TARGET, 64'd9);
		cfg_write(CFG_CSEL, 64'h3FF);
		cfg_write(CFG_CVAL, 64'h3FF);
		cfg_write(CFG_C00, 64'h7FFFFFFF_7FFFFFFF);
		cfg_write(CFG_C01, 64'h7FFFFFFF_7FFFFFFF);
		cfg_write(CFG_C10, 64'h80000000_80000000);
		cfg_write(CFG_C11, 64'hFFFFFFFF_FFFFFFFF);
		send(REQ_APPLY, '0, '0, '0);
		send(REQ_READ, 10'h1FF, '0, '0);
		send(REQ_READ, 10'h3FF, '0, '0);
		drain();

		// Target zero, no controls, -2, zero, all-ones coefs: a saturating sweep
		cfg_write(CFG_TARGET, 64'd0);
		cfg_write(CFG_CSEL, 64'd0);
		cfg_write(CFG_CVAL, 64'd0);
		cfg_write(CFG_C00, 64'h80000000_00000000);
		cfg_write(CFG_C01, 64'h80000000_00000000);
		cfg_write(CFG_C10, 64'h0);
		cfg_write(CFG_C11, 64'hFFFFFFFF_FFFFFFFF);
		send(REQ_APPLY, '0, '0, '0);
		send(REQ_READ, 10'd0, '0, '0);
		send(REQ_READ, 10'd1, '0, '0);
		drain();

		// Random phases: new config while idle, then a mix of requests
		done = 0;
		while (done < RandItems) begin
			random_config();
			burst = ($urandom_range(0, 4) == 0);
			for (int j = 0; j < 60 && done < RandItems; j++) begin
				k = $urandom_range(0, 99);
				if (k < 45) begin
					send(REQ_WRITE, idx_t'($urandom), $urandom, $urandom);
					done++;
				end else if (k < 88) begin
					send(REQ_READ, idx_t'($urandom), '0, '0);
					done++;
				end else if (k < 96) begin
					send(REQ_APPLY, idx_t'($urandom), $urandom, $urandom);
					done++;
				end else begin
					send(REQ_NONE, idx_t'($urandom), $urandom, $urandom);
				end
			end
			burst = 1'b0;
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
